>>> hdl/fat_volume_geometry_parser_core_defines.svh
// Assertion macros shared by the checker of the FAT geometry parser.
`ifndef FAT_VOLUME_GEOMETRY_PARSER_CORE_DEFINES_SVH
`define FAT_VOLUME_GEOMETRY_PARSER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define FVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A stalled item keeps valid high and its payload unchanged.
`define FVG_ASSERT_HOLD(lbl, vld, rdy, pay, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        ((vld) && !(rdy) |=> (vld) && $stable(pay))) else $error(msg);

`endif

>>> hdl/fvg_pkg.sv
// Types and constants of the FAT volume geometry parser.
`default_nettype none

package fvg_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int POS_W        = $clog2(SECTOR_BYTES);
    localparam int UNIT_SHIFT   = $clog2(SECTOR_BYTES);
    localparam int DIRENT_SHIFT = 5;                         // 32-byte directory entries
    localparam int DPS_SHIFT    = UNIT_SHIFT - DIRENT_SHIFT; // entries per sector, log2

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 160;

    // commands on s_axis_tuser
    localparam logic [1:0] CMD_MBR     = 2'd0;
    localparam logic [1:0] CMD_BOOT    = 2'd1;
    localparam logic [1:0] CMD_CLUSTER = 2'd2;

    // result kinds on m_axis_tuser
    localparam logic [1:0] KIND_PART    = 2'd0;
    localparam logic [1:0] KIND_GEOM    = 2'd1;
    localparam logic [1:0] KIND_CLUSTER = 2'd2;

    // sector byte offsets
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(SECTOR_BYTES - 1);
    localparam logic [POS_W-1:0] MBR_SIG_FST  = POS_W'(3);
    localparam logic [POS_W-1:0] MBR_SIG_LST  = POS_W'(7);
    localparam logic [POS_W-1:0] MBR_PART_OFS = POS_W'(16'h01C6);
    localparam logic [POS_W-1:0] BS_SPC       = POS_W'(16'h000D);
    localparam logic [POS_W-1:0] BS_RSVD      = POS_W'(16'h000E);
    localparam logic [POS_W-1:0] BS_NFATS     = POS_W'(16'h0010);
    localparam logic [POS_W-1:0] BS_ROOTENT   = POS_W'(16'h0011);
    localparam logic [POS_W-1:0] BS_FATSZ16   = POS_W'(16'h0016);
    localparam logic [POS_W-1:0] BS_FATSZ32   = POS_W'(16'h0024);
    localparam logic [POS_W-1:0] BS_ROOTCLUS  = POS_W'(44);

    localparam logic [2:0] SIG_FULL = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] fat_start;
        logic [31:0] fat_length;
        logic [31:0] root_start;
        logic [7:0]  cluster_size;
        logic [15:0] root_entry_count;
        logic        is_fat16;
        logic        boot_first;
    } t_result;

    typedef struct packed {
        logic [31:0] fat_end;       // FAT base plus FAT span
        logic [7:0]  spc;
        logic [15:0] root_entries;
        logic        fat16;
    } t_geom;

    // "MSDOS" letter at signature index
    function automatic logic [7:0] dos_letter(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h4D;
            3'd1:    ch = 8'h53;
            3'd2:    ch = 8'h44;
            3'd3:    ch = 8'h4F;
            3'd4:    ch = 8'h53;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fat_volume_geometry_parser_core.sv
// Stages: an item is registered at the input stage, then its result at the output stage.
// Throughput: one item per cycle while m_axis_tready is high; the input register
// and the output register advance together and stall only on a held result.
// Reset: synchronous active-low i_rst_n clears both stages, all parsed fields and
// the byte counter; byte addressing comes up set. No clearing pass.
`default_nettype none

module fat_volume_geometry_parser_core
    import fvg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration: byte_addressing
    input  wire logic                   i_cfg_wr_en,
    input  wire logic                   i_cfg_wr_data,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], cluster_number[35:8]
    input  wire logic [1:0]             s_axis_tuser,  // command[1:0]
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // address[31:0], fat_start[63:32],
                                                       // fat_length[95:64], root_start[127:96],
                                                       // cluster_size[135:128],
                                                       // root_entry_count[151:136],
                                                       // is_fat16[152],
                                                       // boot_in_first_sector[153]
    output logic [1:0]                  m_axis_tuser   // result_kind[1:0]
);

    logic        r_byte_addr;

    // input stage
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [27:0] r_in_cluster;

    // output stage
    logic        r_out_valid;
    t_result     r_res;

    logic        advance;
    logic        sec_valid;
    t_result     sec_res;
    t_geom       geom;
    logic [31:0] clus_addr;
    logic        res_valid;
    t_result     res;

    // the input stage moves on whenever the output register is free or drains
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_addr <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_byte_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd     <= s_axis_tuser;
            r_in_byte    <= s_axis_tdata[7:0];
            r_in_cluster <= s_axis_tdata[35:8];
        end
    end

    // sector bytes: counter, field capture, geometry at the last byte
    fvg_sector_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_cmd       (r_in_cmd),
        .i_byte      (r_in_byte),
        .i_byte_addr (r_byte_addr),
        .o_geom      (geom),
        .o_res_valid (sec_valid),
        .o_res       (sec_res)
    );

    // cluster queries read the geometry as it stands
    fvg_cluster_map u_map (
        .i_cluster   (r_in_cluster),
        .i_geom      (geom),
        .i_byte_addr (r_byte_addr),
        .o_address   (clus_addr)
    );

    always_comb begin
        res_valid = sec_valid;
        res       = sec_res;
        if (r_in_cmd == CMD_CLUSTER) begin
            res_valid   = 1'b1;
            res         = '0;
            res.kind    = KIND_CLUSTER;
            res.address = clus_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {6'd0, r_res.boot_first, r_res.is_fat16, r_res.root_entry_count,
                            r_res.cluster_size, r_res.root_start, r_res.fat_length,
                            r_res.fat_start, r_res.address};

endmodule

`default_nettype wire

>>> hdl/fvg_sector_parser.sv
// Byte-serial MBR and boot sector field capture with geometry results.
`default_nettype none

module fvg_sector_parser
    import fvg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_byte_addr,
    output t_geom            o_geom,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_sig, n_sig;
    logic [31:0]      r_part, n_part;
    logic [7:0]       r_spc, n_spc;
    logic [15:0]      r_rsvd, n_rsvd;
    logic [31:0]      r_fatsz, n_fatsz;
    logic [7:0]       r_nfats, n_nfats;
    logic [15:0]      r_rootent, n_rootent;
    logic [31:0]      r_rootloc, n_rootloc;
    logic             r_fat16, n_fat16;
    logic [31:0]      r_fat_end, n_fat_end;
    logic [31:0]      r_base_pre, r_span_pre;

    logic [POS_W-1:0] sig_idx, part_idx, rsvd_idx, ent_idx, f16_idx, f32_idx, rc_idx;
    logic [31:0]      fat_prod;
    logic [31:0]      geom_sum;

    assign sig_idx  = r_pos - MBR_SIG_FST;
    assign part_idx = r_pos - MBR_PART_OFS;
    assign rsvd_idx = r_pos - BS_RSVD;
    assign ent_idx  = r_pos - BS_ROOTENT;
    assign f16_idx  = r_pos - BS_FATSZ16;
    assign f32_idx  = r_pos - BS_FATSZ32;
    assign rc_idx   = r_pos - BS_ROOTCLUS;

    // FAT base and span settle long before the last byte; keep them registered
    assign fat_prod = r_fatsz * {24'd0, r_nfats};
    assign geom_sum = r_base_pre + r_span_pre;

    always_comb begin
        n_pos     = r_pos;
        n_sig     = r_sig;
        n_part    = r_part;
        n_spc     = r_spc;
        n_rsvd    = r_rsvd;
        n_fatsz   = r_fatsz;
        n_nfats   = r_nfats;
        n_rootent = r_rootent;
        n_rootloc = r_rootloc;
        n_fat16   = r_fat16;
        n_fat_end = r_fat_end;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_en && i_cmd == CMD_MBR) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_part = '0;
                n_sig  = '0;
            end
            if (r_pos >= MBR_SIG_FST && r_pos <= MBR_SIG_LST
                    && i_byte == dos_letter(sig_idx[2:0])) begin
                n_sig = n_sig + 1'b1;
            end
            if (r_pos >= MBR_PART_OFS && part_idx < POS_W'(4)) begin
                n_part[8*part_idx[1:0] +: 8] = n_part[8*part_idx[1:0] +: 8] | i_byte;
            end
            if (r_pos == POS_LAST) begin
                if (n_sig == SIG_FULL) begin
                    n_part = '0;
                end else if (i_byte_addr) begin
                    n_part = n_part << UNIT_SHIFT;
                end
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_PART;
                o_res.address    = n_part;
                o_res.boot_first = (n_sig == SIG_FULL);
            end
        end else if (i_en && i_cmd == CMD_BOOT) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_spc     = '0;
                n_rsvd    = '0;
                n_fatsz   = '0;
                n_nfats   = '0;
                n_rootent = '0;
                n_rootloc = '0;
                n_fat16   = 1'b0;
            end
            if (r_pos == BS_SPC) begin
                n_spc = n_spc | i_byte;
            end
            if (r_pos >= BS_RSVD && rsvd_idx < POS_W'(2)) begin
                n_rsvd[8*rsvd_idx[0] +: 8] = n_rsvd[8*rsvd_idx[0] +: 8] | i_byte;
            end
            if (r_pos == BS_NFATS) begin
                n_nfats = n_nfats | i_byte;
            end
            if (r_pos >= BS_ROOTENT && ent_idx < POS_W'(2)) begin
                n_rootent[8*ent_idx[0] +: 8] = n_rootent[8*ent_idx[0] +: 8] | i_byte;
            end
            if (r_pos >= BS_FATSZ16 && f16_idx < POS_W'(2)) begin
                n_fatsz[8*f16_idx[0] +: 8] = n_fatsz[8*f16_idx[0] +: 8] | i_byte;
                if (i_byte != 8'd0) begin
                    n_fat16 = 1'b1;
                end
            end
            // 32-bit FAT size only counts when the 16-bit field was zero
            if (r_pos >= BS_FATSZ32 && f32_idx < POS_W'(4) && !n_fat16) begin
                n_fatsz[8*f32_idx[1:0] +: 8] = n_fatsz[8*f32_idx[1:0] +: 8] | i_byte;
            end
            if (r_pos >= BS_ROOTCLUS && rc_idx < POS_W'(4)) begin
                n_rootloc[8*rc_idx[1:0] +: 8] = n_rootloc[8*rc_idx[1:0] +: 8] | i_byte;
            end
            if (r_pos == POS_LAST) begin
                n_fat_end = geom_sum;
                if (n_fat16) begin
                    n_rootloc = geom_sum;
                end
                o_res_valid            = 1'b1;
                o_res.kind             = KIND_GEOM;
                o_res.fat_start        = r_base_pre;
                o_res.fat_length       = r_span_pre;
                o_res.root_start       = n_rootloc;
                o_res.cluster_size     = n_spc;
                o_res.root_entry_count = n_rootent;
                o_res.is_fat16         = n_fat16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sig      <= '0;
            r_part     <= '0;
            r_spc      <= '0;
            r_rsvd     <= '0;
            r_fatsz    <= '0;
            r_nfats    <= '0;
            r_rootent  <= '0;
            r_rootloc  <= '0;
            r_fat16    <= 1'b0;
            r_fat_end  <= '0;
            r_base_pre <= '0;
            r_span_pre <= '0;
        end else begin
            r_pos      <= n_pos;
            r_sig      <= n_sig;
            r_part     <= n_part;
            r_spc      <= n_spc;
            r_rsvd     <= n_rsvd;
            r_fatsz    <= n_fatsz;
            r_nfats    <= n_nfats;
            r_rootent  <= n_rootent;
            r_rootloc  <= n_rootloc;
            r_fat16    <= n_fat16;
            r_fat_end  <= n_fat_end;
            r_base_pre <= r_part + (i_byte_addr ? 32'({r_rsvd, {UNIT_SHIFT{1'b0}}})
                                                : {16'd0, r_rsvd});
            r_span_pre <= i_byte_addr ? (fat_prod << UNIT_SHIFT) : fat_prod;
        end
    end

    assign o_geom.fat_end      = r_fat_end;
    assign o_geom.spc          = r_spc;
    assign o_geom.root_entries = r_rootent;
    assign o_geom.fat16        = r_fat16;

endmodule

`default_nettype wire

>>> hdl/fvg_cluster_map.sv
// Cluster number to first sector address translation.
`default_nettype none

module fvg_cluster_map
    import fvg_pkg::*;
(
    input  wire logic [27:0] i_cluster,
    input  wire t_geom       i_geom,
    input  wire logic        i_byte_addr,
    output logic [31:0]      o_address
);

    logic [31:0] rel_clus;
    logic [31:0] rel_sect;
    logic [31:0] dir_ofs;

    assign rel_clus = {4'd0, i_cluster} - 32'd2;
    assign rel_sect = rel_clus * {24'd0, i_geom.spc};

    // root dir size: entries*32 bytes, whole sectors on FAT16 block cards, else 0
    always_comb begin
        if (i_byte_addr) begin
            dir_ofs = 32'({i_geom.root_entries, {DIRENT_SHIFT{1'b0}}});
        end else if (i_geom.fat16) begin
            dir_ofs = 32'(i_geom.root_entries >> DPS_SHIFT)
                    + 32'(i_geom.root_entries[DPS_SHIFT-1:0] != '0);
        end else begin
            dir_ofs = '0;
        end
    end

    assign o_address = i_geom.fat_end + dir_ofs
                     + (i_byte_addr ? (rel_sect << UNIT_SHIFT) : rel_sect);

endmodule

`default_nettype wire

>>> hdl/fvg_checker.sv
// Port-level checks for the FAT geometry parser, bound to the top level.
`default_nettype none
`include "fat_volume_geometry_parser_core_defines.svh"

module fvg_checker
    import fvg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [1:0]             m_axis_tuser
);

    logic [OUT_TDATA_W+1:0] out_item;
    logic                   out_stall;
    logic                   is_part;
    logic                   is_clus;
    logic                   part_zero;
    logic                   clus_zero;
    logic                   kind_known;

    assign out_item   = {m_axis_tuser, m_axis_tdata};
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign is_part    = m_axis_tvalid && (m_axis_tuser == KIND_PART);
    assign is_clus    = m_axis_tvalid && (m_axis_tuser == KIND_CLUSTER);
    assign part_zero  = (m_axis_tdata[152:32] == '0) && (m_axis_tdata[OUT_TDATA_W-1:154] == '0);
    assign clus_zero  = (m_axis_tdata[OUT_TDATA_W-1:32] == '0);
    assign kind_known = (m_axis_tuser == KIND_PART) || (m_axis_tuser == KIND_GEOM)
                     || (m_axis_tuser == KIND_CLUSTER);

    `FVG_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, out_item, "result moved in stall")

    // input only backs up behind a held result
    `FVG_ASSERT(a_in_stall, !s_axis_tready |-> out_stall, "input stalled without backpressure")

    `FVG_ASSERT(a_part_fields, is_part |-> part_zero, "partition result has extra fields")

    `FVG_ASSERT(a_clus_fields, is_clus |-> clus_zero, "cluster result has extra fields")

    `FVG_ASSERT(a_kind_code, m_axis_tvalid |-> kind_known, "unknown result kind")

endmodule

bind fat_volume_geometry_parser_core fvg_checker u_fvg_checker (.*);

`default_nettype wire

>>> tb/fat_volume_geometry_parser_core_checker.sv
// Checker for the FAT volume geometry parser: predicts each result and compares it by field.
`timescale 1ns / 100ps

module fat_volume_geometry_parser_core_checker
    import fvg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic                   i_cfg_wr_data,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   i_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // data_byte[7:0], cluster_number[35:8]
    input  wire logic [1:0]             i_s_axis_tuser,   // command[1:0]
    input  wire logic                   i_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  wire logic [1:0]             i_m_axis_tuser,   // result_kind[1:0]
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);

    localparam logic [39:0] DOS_TEXT     = "MSDOS";
    localparam int          DIRENT_BYTES = 32;
    localparam int          DIRENTS_PER_SECTOR = SECTOR_BYTES / DIRENT_BYTES;

    // predicted block state
    logic             byte_addr  = 1'b1;
    logic [POS_W-1:0] sec_pos    = '0;
    logic [2:0]       mark_hits  = '0;
    logic [31:0]      part_base  = '0;
    logic [7:0]       spc        = '0;
    logic [15:0]      rsvd       = '0;
    logic [31:0]      fat_sz     = '0;
    logic [7:0]       nfats      = '0;
    logic [15:0]      root_ent   = '0;
    logic [31:0]      root_loc   = '0;
    logic             fat16      = 1'b0;
    logic [31:0]      fat_base   = '0;
    logic [31:0]      fat_span   = '0;

    t_result geometry_q[$];
    int      fails   = 0;
    int      results = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic step_geometry(input logic [1:0] cmd, input logic [7:0] b,
                                 input logic [27:0] clus, output bit emits,
                                 output t_result res);
        logic [31:0] unit;
        logic [31:0] rel;
        logic [31:0] fat_end;
        logic        marked;
        unit  = byte_addr ? 32'(SECTOR_BYTES) : 32'd1;
        res   = '0;
        emits = 1'b0;
        case (cmd)
            CMD_MBR: begin
                if (sec_pos == '0) begin
                    part_base = '0;
                    mark_hits = '0;
                end
                if (sec_pos >= MBR_SIG_FST && sec_pos <= MBR_SIG_LST) begin
                    if (b == DOS_TEXT[8 * (MBR_SIG_LST - sec_pos) +: 8])
                        mark_hits = mark_hits + 3'd1;
                end
                if (sec_pos >= MBR_PART_OFS && sec_pos <= MBR_PART_OFS + 3)
                    part_base = part_base | (32'(b) << (8 * (sec_pos - MBR_PART_OFS)));
                if (sec_pos == POS_LAST) begin
                    marked         = (mark_hits == SIG_FULL);
                    part_base      = marked ? 32'd0 : part_base * unit;
                    emits          = 1'b1;
                    res.kind       = KIND_PART;
                    res.address    = part_base;
                    res.boot_first = marked;
                end
            end
            CMD_BOOT: begin
                if (sec_pos == '0) begin
                    spc      = '0;
                    rsvd     = '0;
                    fat_sz   = '0;
                    nfats    = '0;
                    root_ent = '0;
                    root_loc = '0;
                    fat16    = 1'b0;
                end
                if (sec_pos == BS_SPC)
                    spc = spc | b;
                if (sec_pos == BS_RSVD || sec_pos == BS_RSVD + 1)
                    rsvd = rsvd | (16'(b) << (8 * (sec_pos - BS_RSVD)));
                if (sec_pos == BS_NFATS)
                    nfats = nfats | b;
                if (sec_pos == BS_ROOTENT || sec_pos == BS_ROOTENT + 1)
                    root_ent = root_ent | (16'(b) << (8 * (sec_pos - BS_ROOTENT)));
                if (sec_pos == BS_FATSZ16 || sec_pos == BS_FATSZ16 + 1) begin
                    fat_sz = fat_sz | (32'(b) << (8 * (sec_pos - BS_FATSZ16)));
                    if (b != 8'd0)
                        fat16 = 1'b1;
                end
                // 32-bit FAT size only counts while no 16-bit size was seen
                if (sec_pos >= BS_FATSZ32 && sec_pos <= BS_FATSZ32 + 3 && !fat16)
                    fat_sz = fat_sz | (32'(b) << (8 * (sec_pos - BS_FATSZ32)));
                if (sec_pos >= BS_ROOTCLUS && sec_pos <= BS_ROOTCLUS + 3)
                    root_loc = root_loc | (32'(b) << (8 * (sec_pos - BS_ROOTCLUS)));
                if (sec_pos == POS_LAST) begin
                    fat_base = part_base + 32'(rsvd) * unit;
                    fat_span = fat_sz * 32'(nfats) * unit;
                    if (fat16)
                        root_loc = fat_base + fat_span;
                    emits                = 1'b1;
                    res.kind             = KIND_GEOM;
                    res.fat_start        = fat_base;
                    res.fat_length       = fat_span;
                    res.root_start       = root_loc;
                    res.cluster_size     = spc;
                    res.root_entry_count = root_ent;
                    res.is_fat16         = fat16;
                end
            end
            CMD_CLUSTER: begin
                rel     = (32'(clus) - 32'd2) * 32'(spc);
                fat_end = fat_base + fat_span;
                emits    = 1'b1;
                res.kind = KIND_CLUSTER;
                if (byte_addr)
                    res.address = fat_end + 32'(root_ent) * 32'(DIRENT_BYTES)
                                + rel * 32'(SECTOR_BYTES);
                else if (fat16)
                    res.address = fat_end + 32'(root_ent) / 32'(DIRENTS_PER_SECTOR) + rel
                                + ((32'(root_ent) % 32'(DIRENTS_PER_SECTOR) != 0) ? 32'd1 : 32'd0);
                else
                    res.address = fat_end + rel;
            end
            default: ;
        endcase
        if (cmd == CMD_MBR || cmd == CMD_BOOT)
            sec_pos = sec_pos + 1'b1;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        t_result pred;
        bit      emits;
        if (!i_rst_n) begin
            byte_addr = 1'b1;
            sec_pos   = '0;
            mark_hits = '0;
            part_base = '0;
            spc       = '0;
            rsvd      = '0;
            fat_sz    = '0;
            nfats     = '0;
            root_ent  = '0;
            root_loc  = '0;
            fat16     = 1'b0;
            fat_base  = '0;
            fat_span  = '0;
            geometry_q.delete();
        end else begin
            if (i_cfg_wr_en)
                byte_addr = i_cfg_wr_data;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.kind             = i_m_axis_tuser;
                got.address          = i_m_axis_tdata[31:0];
                got.fat_start        = i_m_axis_tdata[63:32];
                got.fat_length       = i_m_axis_tdata[95:64];
                got.root_start       = i_m_axis_tdata[127:96];
                got.cluster_size     = i_m_axis_tdata[135:128];
                got.root_entry_count = i_m_axis_tdata[151:136];
                got.is_fat16         = i_m_axis_tdata[152];
                got.boot_first       = i_m_axis_tdata[153];
                results++;
                if (geometry_q.size() == 0) begin
                    $error("result of kind %0d with no item waiting for it", got.kind);
                    fails++;
                end else begin
                    want = geometry_q.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(got.kind));
                    check_field("address", want.address, got.address);
                    check_field("fat_start", want.fat_start, got.fat_start);
                    check_field("fat_length", want.fat_length, got.fat_length);
                    check_field("root_start", want.root_start, got.root_start);
                    check_field("cluster_size", 32'(want.cluster_size),
                                32'(got.cluster_size));
                    check_field("root_entry_count", 32'(want.root_entry_count),
                                32'(got.root_entry_count));
                    check_field("is_fat16", 32'(want.is_fat16), 32'(got.is_fat16));
                    check_field("boot_in_first_sector", 32'(want.boot_first),
                                32'(got.boot_first));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                step_geometry(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[35:8],
                              emits, pred);
                if (emits)
                    geometry_q.push_back(pred);
            end
        end
        o_pending      <= geometry_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

>>> tb/fat_volume_geometry_parser_core_tb.sv
// Testbench top for the FAT volume geometry parser: stimulus, idling and final verdict.
`timescale 1ns / 100ps

module fat_volume_geometry_parser_core_tb;
    import fvg_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;   // several times the slowest legal run
    localparam int          SETTLE_CYCLES = 4;        // two pipeline stages plus margin
    localparam int          QUERY_COUNT   = 12;       // cluster queries per addressing mode
    localparam int          NOISE_ODDS    = 40;       // one stray item per this many bytes
    localparam logic [1:0]  CMD_NONE      = 2'd3;     // unused command, the block drops it
    localparam logic [39:0] DOS_TEXT      = "MSDOS";
    localparam logic [27:0] CLUSTER_MAX   = 28'hFFF_FFFF;
    // clusters 0 and 1 make the (cluster - 2) term wrap
    localparam logic [27:0] EDGE_CLUSTERS [4] = '{28'd0, 28'd1, 28'd2, CLUSTER_MAX};

    // Kinds of sector the stimulus can build.
    typedef enum int {
        SEC_MBR_MARKED,
        SEC_BOOT_FAT16,
        SEC_BOOT_FAT32,
        SEC_MBR_PLAIN,
        SEC_BOOT_ANY,
        SEC_MIXED
    } t_sector_plan;

    // Sectors in run order: a partitioned MBR (DOS mark right only by chance),
    // then a FAT16 or FAT32 boot sector at the base that MBR gave, then a
    // sector that mixes MBR and boot bytes and runs without any idling.
    localparam int           RUN_COUNT = 3;
    localparam t_sector_plan RUN_PLAN [RUN_COUNT] = '{SEC_MBR_PLAIN, SEC_BOOT_ANY, SEC_MIXED};

    // byte addressing while each sector kind is parsed; the queries after it run in both modes
    localparam logic ADDR_PLAN [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_wr_data = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // data_byte[7:0], cluster_number[35:8]
    logic [1:0]             s_axis_tuser  = '0;   // command[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // address .. boot_in_first_sector[153]
    logic [1:0]             m_axis_tuser;         // result_kind[1:0]

    int   fail_count;
    int   pending;
    int   result_count;

    logic calm       = 1'b0;   // set for the final stretch: no gaps, no stalls
    int   gap_odds   = 0;      // 0: no sender gaps, else one gap per gap_odds items
    int   stall_left = 0;
    int   cycles     = 0;
    int   n_items    = 0;
    int   n_sectors  = 0;
    int   n_queries  = 0;

    logic [7:0] sector_img [SECTOR_BYTES];

    fat_volume_geometry_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fat_volume_geometry_parser_core_checker geometry_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result-side back pressure: ready runs of random length, then a stall now
    // and then; always ready once calm is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (m_axis_tready) begin
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(0, 17);
            end else begin
                stall_left <= $urandom_range(0, 40);
            end
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= $urandom_range(0, 60);
        end
    end

    // One item on s_axis, with an optional sender gap in front. Valid stays
    // high from one item to the next unless a gap is taken.
    task automatic push_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [27:0] clus);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, clus, b};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        n_items++;
        if (cmd == CMD_CLUSTER)
            n_queries++;
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty of
    // byte items that produce nothing.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_addressing(input logic mode);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Build one sector image for the plan and stream it byte by byte. Later
    // plans drop stray queries and unused commands in between; these leave
    // the byte counter alone.
    task automatic send_sector(input t_sector_plan plan);
        logic [15:0] fat16_size;
        logic        want_fat16;
        logic [1:0]  base_cmd;
        logic [1:0]  cmd;
        int          noise;
        foreach (sector_img[p])
            sector_img[p] = 8'($urandom);
        base_cmd = (plan == SEC_MBR_MARKED || plan == SEC_MBR_PLAIN) ? CMD_MBR : CMD_BOOT;
        noise    = (plan >= SEC_MBR_PLAIN) ? NOISE_ODDS : 0;
        want_fat16 = (plan == SEC_BOOT_FAT16)
                  || (plan == SEC_BOOT_ANY && $urandom_range(0, 1) == 1);
        if (base_cmd == CMD_MBR) begin
            // full DOS mark, or each letter right only by chance
            for (int k = 0; k < 5; k++) begin
                if (plan == SEC_MBR_MARKED || $urandom_range(0, 1) == 1)
                    sector_img[MBR_SIG_FST + k] = DOS_TEXT[8 * (4 - k) +: 8];
            end
        end else if (plan != SEC_MIXED) begin
            // FAT16: at least one nonzero byte in the 16-bit size, sometimes
            // only the high one; FAT32: both zero
            fat16_size = {8'($urandom), ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'd0};
            if (fat16_size == 16'd0)
                fat16_size = 16'h0001;
            if (!want_fat16)
                fat16_size = 16'd0;
            sector_img[BS_FATSZ16]     = fat16_size[7:0];
            sector_img[BS_FATSZ16 + 1] = fat16_size[15:8];
        end
        for (int p = 0; p < SECTOR_BYTES; p++) begin
            if (noise != 0 && $urandom_range(1, noise) == 1)
                push_item(($urandom_range(0, 2) == 0) ? CMD_NONE : CMD_CLUSTER,
                          8'($urandom), 28'($urandom));
            cmd = base_cmd;
            if (plan == SEC_MIXED)
                cmd = ($urandom_range(0, 1) == 1) ? CMD_BOOT : CMD_MBR;
            push_item(cmd, sector_img[p], 28'($urandom));
        end
        n_sectors++;
    endtask

    // Cluster queries: the edge clusters first, then small, 16-bit and full
    // 28-bit numbers, with an unused command mixed in now and then.
    task automatic send_queries(input int count);
        logic [27:0] clus;
        for (int i = 0; i < count; i++) begin
            if (i < 4)
                clus = EDGE_CLUSTERS[i];
            else
                case ($urandom_range(0, 2))
                    0:       clus = 28'($urandom_range(2, 100));
                    1:       clus = 28'($urandom_range(0, 65535));
                    default: clus = 28'($urandom);
                endcase
            push_item(($urandom_range(0, 7) == 0) ? CMD_NONE : CMD_CLUSTER,
                      8'($urandom), clus);
        end
    endtask

    initial begin : stimulus
        t_sector_plan plan;
        logic         mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries on the cleared geometry at the reset addressing,
        // edge clusters, and unused commands with all-ones and all-zeros payload.
        foreach (EDGE_CLUSTERS[k])
            push_item(CMD_CLUSTER, 8'hA5, EDGE_CLUSTERS[k]);
        push_item(CMD_NONE, 8'hFF, CLUSTER_MAX);
        push_item(CMD_NONE, 8'h00, 28'd0);
        push_item(CMD_CLUSTER, 8'hFF, 28'h555_5555);
        push_item(CMD_CLUSTER, 8'h00, 28'hAAA_AAAA);

        // One setting per sector in the run; the addressing flips halfway
        // through the queries so both modes see every geometry.
        for (int ph = 0; ph < RUN_COUNT; ph++) begin
            plan = RUN_PLAN[ph];
            mode = ADDR_PLAN[int'(plan)];
            if (plan == SEC_BOOT_ANY)
                mode = 1'($urandom_range(0, 1));
            if (plan == SEC_MIXED) begin
                calm     <= 1'b1;
                gap_odds  = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 4;
                    default: gap_odds = 16;
                endcase
            end
            write_addressing(mode);
            send_sector(plan);
            send_queries(QUERY_COUNT);
            write_addressing(!mode);
            send_queries(QUERY_COUNT);
        end

        settle_block();
        $display("Covered %0d items: %0d sectors (partitioned MBR, FAT boot sector,",
                 n_items, n_sectors);
        $display("  mixed bytes) and %0d cluster queries; %0d results checked, %0d mismatches",
                 n_queries, result_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
